// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/nsqm_pkg.sv =====
`default_nettype none
package nsqm_pkg;

  localparam int unsigned MaxLists  = 16;
  localparam int unsigned PoolNodes = 1024;
  localparam int unsigned DataBits  = 64;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned WordW   = 64;
  localparam int unsigned StatusW = 3;

  typedef enum logic [FuncW-1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_PUSH   = 2'd1,
    FUNC_POP    = 2'd2,
    FUNC_POP_X  = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_EXISTS     = 3'd1,
    ST_MISSING    = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_POOL_FULL  = 3'd5
  } status_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [KeyW-1:0]  list_key;
    logic             make_queue;
    logic [WordW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   popped_value;
    logic               popped_valid;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/nsqm_if.sv =====
`default_nettype none
interface nsqm_cmd_if;
  import nsqm_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nsqm_rsp_if;
  import nsqm_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/nsqm_table.sv =====
`default_nettype none
// List table: in-use bits in flops, key match and lowest free slot search.
module nsqm_table #(
  parameter int unsigned MAX_LISTS = nsqm_pkg::MaxLists,
  localparam int unsigned SlotW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [nsqm_pkg::KeyW-1:0] key_i,
  input  wire logic                     claim_i,
  input  wire logic [SlotW-1:0]         claim_slot_i,
  output logic                          hit_o,
  output logic [SlotW-1:0]              hit_slot_o,
  output logic                          free_o,
  output logic [SlotW-1:0]              free_slot_o
);
  import nsqm_pkg::*;

  logic [MAX_LISTS-1:0] in_use_q;
  logic [KeyW-1:0]      key_q [MAX_LISTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (claim_i) begin
      in_use_q[claim_slot_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (claim_i) begin
      key_q[claim_slot_i] <= key_i;
    end
  end

  // Scan from the top so the lowest index wins.
  always_comb begin
    hit_o       = 1'b0;
    hit_slot_o  = '0;
    free_o      = 1'b0;
    free_slot_o = '0;
    for (int i = MAX_LISTS - 1; i >= 0; i--) begin
      if (in_use_q[i] && key_q[i] == key_i) begin
        hit_o      = 1'b1;
        hit_slot_o = SlotW'(i);
      end
      if (!in_use_q[i]) begin
        free_o      = 1'b1;
        free_slot_o = SlotW'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/named_stack_queue_manager.sv =====
`default_nettype none
// A command is taken in S_IDLE, looked up and read in S_READ, written back in S_WRITE,
// and its result is valid in S_RESP until taken; then S_IDLE accepts again.
// Only one command is in flight; the response register holds until taken.
// Reset: asynchronous, active low; clears list in-use bits and pool counters.
// Memories need no clearing pass; entries are written before they are read.
module named_stack_queue_manager #(
  parameter int unsigned MAX_LISTS  = nsqm_pkg::MaxLists,
  parameter int unsigned POOL_NODES = nsqm_pkg::PoolNodes,
  parameter int unsigned DATA_BITS  = nsqm_pkg::DataBits
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  nsqm_cmd_if.sink   cmd_i,
  nsqm_rsp_if.source rsp_o
);
  import nsqm_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned SlotW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int unsigned NodeW = $clog2(POOL_NODES);
  localparam int unsigned CntW  = NodeW + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_WRITE = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  typedef struct packed {
    logic             is_queue;
    logic [NodeW-1:0] head;
    logic [NodeW-1:0] tail;
    logic [CntW-1:0]  count;
  } list_t;

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic   hit_q;
  logic [SlotW-1:0] slot_q;
  logic   free_q;
  logic [SlotW-1:0] free_slot_q;

  logic [CntW-1:0]  fresh_q;
  logic [NodeW-1:0] free_head_q;
  logic [CntW-1:0]  free_cnt_q;

  list_t            list_mem [MAX_LISTS];
  logic [DATA_BITS-1:0] val_mem [POOL_NODES];
  logic [NodeW-1:0] nxt_mem [POOL_NODES];

  list_t            list_rd_q;
  logic [DATA_BITS-1:0] val_rd_q;
  logic [NodeW-1:0] nxt_rd_q;

  logic             hit, free_ok;
  logic [SlotW-1:0] hit_slot, free_slot;
  logic             claim;
  rsp_t             rsp_q;

  nsqm_table #(.MAX_LISTS(MAX_LISTS)) u_table (
    .clk_i,
    .rst_ni,
    .key_i        (cmd_q.list_key),
    .claim_i      (claim),
    .claim_slot_i (free_slot_q),
    .hit_o        (hit),
    .hit_slot_o   (hit_slot),
    .free_o       (free_ok),
    .free_slot_o  (free_slot)
  );

  assign cmd_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = (state_q == S_RESP);
  assign rsp_o.data  = rsp_q;

  wire logic is_create = (func_e'(cmd_q.func) == FUNC_CREATE);
  wire logic is_push   = (func_e'(cmd_q.func) == FUNC_PUSH);
  wire logic is_pop    = !is_create && !is_push;

  // Address of the node memory read in S_READ: pop reads the head, push the free head.
  logic [NodeW-1:0] node_rd_addr;
  assign node_rd_addr = is_pop ? list_mem[hit_slot].head : free_head_q;

  // Node to take for a push.
  wire logic             use_free = (free_cnt_q != '0);
  wire logic             pool_ok  = use_free || (fresh_q < CntW'(POOL_NODES));
  wire logic [NodeW-1:0] new_node = use_free ? free_head_q : fresh_q[NodeW-1:0];

  assign claim = (state_q == S_WRITE) && is_create && !hit_q && free_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (cmd_i.valid) state_d = S_READ;
      S_READ:  state_d = S_WRITE;
      S_WRITE: state_d = S_RESP;
      S_RESP:  if (rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fresh_q     <= '0;
      free_head_q <= '0;
      free_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_WRITE && hit_q) begin
        if (is_push && pool_ok) begin
          if (use_free) begin
            free_head_q <= nxt_rd_q;
            free_cnt_q  <= free_cnt_q - 1'b1;
          end else begin
            fresh_q <= fresh_q + 1'b1;
          end
        end else if (is_pop && list_rd_q.count != '0) begin
          free_head_q <= list_rd_q.head;
          free_cnt_q  <= free_cnt_q + 1'b1;
        end
      end
    end
  end

  // Command capture, lookup registers and memory reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      cmd_q <= cmd_i.data;
    end
    if (state_q == S_READ) begin
      hit_q       <= hit;
      slot_q      <= hit_slot;
      free_q      <= free_ok;
      free_slot_q <= free_slot;
      list_rd_q   <= list_mem[hit_slot];
      val_rd_q    <= val_mem[node_rd_addr];
      nxt_rd_q    <= nxt_mem[node_rd_addr];
    end
  end

  // Write-back of list descriptor and node memory.
  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      if (claim) begin
        list_mem[free_slot_q] <= '{is_queue: cmd_q.make_queue, head: '0, tail: '0,
                                   count: '0};
      end else if (hit_q && is_push && pool_ok) begin
        val_mem[new_node] <= cmd_q.value[DATA_BITS-1:0];
        if (list_rd_q.count == '0) begin
          nxt_mem[new_node] <= '0;
          list_mem[slot_q]  <= '{is_queue: list_rd_q.is_queue, head: new_node,
                                 tail: new_node, count: list_rd_q.count + 1'b1};
        end else if (list_rd_q.is_queue) begin
          // Link behind the tail; the tail's own link is never followed.
          nxt_mem[list_rd_q.tail] <= new_node;
          list_mem[slot_q] <= '{is_queue: 1'b1, head: list_rd_q.head, tail: new_node,
                                count: list_rd_q.count + 1'b1};
        end else begin
          nxt_mem[new_node] <= list_rd_q.head;
          list_mem[slot_q]  <= '{is_queue: 1'b0, head: new_node, tail: list_rd_q.tail,
                                 count: list_rd_q.count + 1'b1};
        end
      end else if (hit_q && is_pop && list_rd_q.count != '0) begin
        nxt_mem[list_rd_q.head] <= free_head_q;
        list_mem[slot_q] <= '{is_queue: list_rd_q.is_queue, head: nxt_rd_q,
                              tail: list_rd_q.tail, count: list_rd_q.count - 1'b1};
      end
    end
  end

  // Response register.
  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      rsp_q.popped_value <= '0;
      rsp_q.popped_valid <= 1'b0;
      if (is_create) begin
        rsp_q.status <= hit_q ? ST_EXISTS : (free_q ? ST_OK : ST_TABLE_FULL);
      end else if (!hit_q) begin
        rsp_q.status <= ST_MISSING;
      end else if (is_push) begin
        rsp_q.status <= pool_ok ? ST_OK : ST_POOL_FULL;
      end else if (list_rd_q.count == '0) begin
        rsp_q.status <= ST_EMPTY;
      end else begin
        rsp_q.status       <= ST_OK;
        rsp_q.popped_value <= WordW'(val_rd_q);
        rsp_q.popped_valid <= 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_one_side, clk_i, rst_ni, !(cmd_i.ready && rsp_o.valid))
  `ASSERT_ALWAYS(a_pool_bound, clk_i, rst_ni, fresh_q <= CntW'(POOL_NODES))
  `ASSERT_ALWAYS(a_free_bound, clk_i, rst_ni, free_cnt_q <= fresh_q)
  `ASSERT_NEXT(a_read_write, clk_i, rst_ni, state_q == S_READ, state_q == S_WRITE)

endmodule
`default_nettype wire

// ===== tb/tb_named_stack_queue_manager.sv =====
`default_nettype none
module tb_named_stack_queue_manager;
  timeunit 1ns;
  timeprecision 1ps;
  import nsqm_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned NodeW = $clog2(PoolNodes);

  class list_pool_scoreboard;
    bit                 slot_used [MaxLists];
    logic [KeyW-1:0]    slot_key  [MaxLists];
    bit                 slot_fifo [MaxLists];
    logic [NodeW-1:0]   slot_head [MaxLists];
    logic [NodeW-1:0]   slot_tail [MaxLists];
    int unsigned        slot_len  [MaxLists];
    logic [WordW-1:0]   node_word [PoolNodes];
    logic [NodeW-1:0]   node_link [PoolNodes];
    int unsigned        fresh_nodes;
    logic [NodeW-1:0]   spare_head;
    int unsigned        spare_len;
    rsp_t               expected_rsps[$];
    int unsigned        mismatches;

    function void clear_state();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      fresh_nodes = 0;
      spare_head  = '0;
      spare_len   = 0;
      mismatches  = 0;
    endfunction

    function int lookup(logic [KeyW-1:0] key);
      foreach (slot_used[i])
        if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    // Work out the response to one accepted command word and queue it.
    function void note_cmd(cmd_t c);
      rsp_t r;
      int s;
      int f;
      logic [NodeW-1:0] n;
      r = '0;
      r.status = ST_OK;
      s = lookup(c.list_key);
      if (func_e'(c.func) == FUNC_CREATE) begin
        f = -1;
        foreach (slot_used[i])
          if (!slot_used[i] && f < 0) f = i;
        if (s >= 0) r.status = ST_EXISTS;
        else if (f < 0) r.status = ST_TABLE_FULL;
        else begin
          slot_used[f] = 1'b1;
          slot_key[f]  = c.list_key;
          slot_fifo[f] = c.make_queue;
          slot_len[f]  = 0;
        end
      end else if (func_e'(c.func) == FUNC_PUSH) begin
        if (s < 0) r.status = ST_MISSING;
        else if (spare_len == 0 && fresh_nodes >= PoolNodes) r.status = ST_POOL_FULL;
        else begin
          // Reuse freed nodes before untouched ones
          if (spare_len > 0) begin
            n = spare_head;
            spare_head = node_link[n];
            spare_len--;
          end else begin
            n = NodeW'(fresh_nodes);
            fresh_nodes++;
          end
          node_word[n] = c.value;
          node_link[n] = '0;
          if (slot_len[s] == 0) begin
            slot_head[s] = n;
            slot_tail[s] = n;
          end else if (slot_fifo[s]) begin
            node_link[slot_tail[s]] = n;
            slot_tail[s] = n;
          end else begin
            node_link[n] = slot_head[s];
            slot_head[s] = n;
          end
          slot_len[s]++;
        end
      end else begin
        if (s < 0) r.status = ST_MISSING;
        else if (slot_len[s] == 0) r.status = ST_EMPTY;
        else begin
          n = slot_head[s];
          r.popped_value = node_word[n];
          r.popped_valid = 1'b1;
          slot_head[s] = node_link[n];
          slot_len[s]--;
          node_link[n] = spare_head;
          spare_head = n;
          spare_len++;
        end
      end
      expected_rsps = {expected_rsps, r};
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_rsp(rsp_t got);
      rsp_t want;
      if (expected_rsps.size() == 0) begin
        report($sformatf("unexpected word status=%0d", got.status));
        return;
      end
      want = expected_rsps.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.popped_value !== want.popped_value)
        report($sformatf("popped_value %h, want %h", got.popped_value, want.popped_value));
      if (got.popped_valid !== want.popped_valid)
        report($sformatf("popped_valid %b, want %b", got.popped_valid, want.popped_valid));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic [KeyW-1:0] key_set [20];
  list_pool_scoreboard sb;

  nsqm_cmd_if cmd ();
  nsqm_rsp_if rsp ();

  named_stack_queue_manager i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd.sink),
    .rsp_o  (rsp.source)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    cmd.valid = 1'b0;
    cmd.data  = '0;
    rsp.ready = 1'b0;
    sb = new();
    sb.clear_state();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("FAIL named_stack_queue_manager");
      $finish;
    end
  end

  // Check accepted results and draw the next ready
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) sb.check_rsp(rsp.data);
    rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send(func_e f, logic [KeyW-1:0] key, logic mq, logic [WordW-1:0] v);
    cmd_t c;
    c.func = f;
    c.list_key = key;
    c.make_queue = mq;
    c.value = v;
    cmd.valid <= 1'b1;
    cmd.data  <= c;
    do @(posedge clk_i); while (!cmd.ready);
    sb.note_cmd(c);
    if ($urandom_range(99) < idle_pct) begin
      cmd.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (sb.expected_rsps.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // push_pct: share of the push-or-pop draws that are pushes
  task automatic random_phase(int unsigned items, int unsigned push_pct);
    int unsigned r;
    logic [KeyW-1:0] k;
    repeat (items) begin
      r = $urandom_range(99);
      k = key_set[$urandom_range(19)];
      if (r < 2)
        send(func_e'($urandom_range(3)), KeyW'($urandom), 1'($urandom_range(1)),
             rand_word());
      else if (r < 7)
        send(FUNC_CREATE, k, 1'($urandom_range(1)), rand_word());
      else if (r < 8)
        send(FUNC_POP_X, k, 1'($urandom_range(1)), rand_word());
      else if ($urandom_range(99) < push_pct)
        send(FUNC_PUSH, k, 1'($urandom_range(1)), rand_word());
      else
        send(FUNC_POP, k, 1'($urandom_range(1)), rand_word());
    end
    drain();
  endtask

  initial begin
    key_set[0] = '0;
    key_set[1] = '1;
    for (int i = 2; i < 20; i++) key_set[i] = KeyW'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every command, error statuses
    send(FUNC_POP, '0, 1'b0, '0);
    send(FUNC_PUSH, '1, 1'b1, '1);
    send(FUNC_CREATE, '0, 1'b0, '0);
    send(FUNC_CREATE, '1, 1'b1, '1);
    send(FUNC_CREATE, '0, 1'b1, '0);
    send(FUNC_POP, '0, 1'b0, '0);
    send(FUNC_PUSH, '0, 1'b0, '0);
    send(FUNC_PUSH, '0, 1'b0, '1);
    send(FUNC_PUSH, '1, 1'b1, 64'h0123_4567_89ab_cdef);
    send(FUNC_PUSH, '1, 1'b0, '1);
    send(FUNC_POP, '0, 1'b0, '0);
    send(FUNC_POP_X, '0, 1'b1, '1);
    send(FUNC_POP, '0, 1'b0, '0);
    send(FUNC_POP, '1, 1'b0, '0);
    send(FUNC_POP_X, '1, 1'b0, '0);
    send(FUNC_PUSH, 16'h5a5a, 1'b0, '1);
    drain();

    idle_pct = 0;  stall_pct = 0;  random_phase(600, 98);
    idle_pct = 84; stall_pct = 0;  random_phase(300, 50);
    idle_pct = 0;  stall_pct = 84; random_phase(500, 98);
    idle_pct = 35; stall_pct = 35; random_phase(350, 15);
    idle_pct = 0;  stall_pct = 0;

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_rsps.size() == 0) begin
      $display("PASS named_stack_queue_manager");
    end else begin
      $display("FAIL named_stack_queue_manager");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== named_stack_queue_manager.f =====
+incdir+rtl
rtl/nsqm_pkg.sv
rtl/nsqm_if.sv
rtl/nsqm_table.sv
rtl/named_stack_queue_manager.sv
tb/tb_named_stack_queue_manager.sv
